>>> hw/rtl/greedy_weighted_set_cover_top_defines.svh
// Assertion macros shared by the set cover RTL
`ifndef GREEDY_WEIGHTED_SET_COVER_TOP_DEFINES_SVH
`define GREEDY_WEIGHTED_SET_COVER_TOP_DEFINES_SVH

// check cons in the same cycle as ante
`define GWSC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define GWSC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gwsc_pkg.sv
// Shared types and constants for the greedy weighted set cover block
package gwsc_pkg;

  localparam int DEF_MAX_SETS     = 32;
  localparam int DEF_MAX_ELEMENTS = 128;
  localparam int DEF_COST_WIDTH   = 16;
  localparam int DEF_POP_W        = $clog2(DEF_MAX_ELEMENTS + 1);

  localparam int CMD_W        = 2;
  localparam int SUBSET_W     = 5;
  localparam int ELEM_NUM_W   = 7;
  localparam int COST_IN_W    = 16;
  localparam int LEFT_W       = 8;
  localparam int SET_COUNT_W  = 6;
  localparam int ELEM_COUNT_W = 8;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 8;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 16;

  localparam logic [SET_COUNT_W-1:0]  SET_COUNT_RESET  = 6'd32;
  localparam logic [ELEM_COUNT_W-1:0] ELEM_COUNT_RESET = 8'd128;

  localparam logic [CFG_ADDR_W-1:0] CFG_SET_COUNT     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ELEMENT_COUNT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_COST  = 2'd2,
    CMD_RUN   = 2'd3
  } cmd_t;

endpackage

>>> hw/rtl/gwsc_popcount.sv
// Three-stage registered population count tree
module gwsc_popcount import gwsc_pkg::*; #(
  parameter int WIDTH   = DEF_MAX_ELEMENTS,
  parameter int COUNT_W = DEF_POP_W
) (
  input  logic               clk,
  input  logic [WIDTH-1:0]   bits,
  output logic [COUNT_W-1:0] count
);

  localparam int CHUNKS = (WIDTH + 63) / 64;
  localparam int PAD    = CHUNKS * 64;
  localparam int BYTES  = CHUNKS * 8;

  logic [PAD-1:0] padded;
  logic [3:0]     byte_cnt   [BYTES];
  logic [6:0]     chunk_cnt  [CHUNKS];
  logic [6:0]     chunk_next [CHUNKS];
  logic [8:0]     total_next;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  assign padded = PAD'(bits);

  always_comb begin
    for (int c = 0; c < CHUNKS; c++) begin
      chunk_next[c] = '0;
      for (int k = 0; k < 8; k++) begin
        chunk_next[c] = chunk_next[c] + 7'(byte_cnt[8 * c + k]);
      end
    end
  end

  always_comb begin
    total_next = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      total_next = total_next + 9'(chunk_cnt[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < BYTES; b++) begin
      byte_cnt[b] <= pop8(padded[8 * b +: 8]);
    end
    for (int c = 0; c < CHUNKS; c++) begin
      chunk_cnt[c] <= chunk_next[c];
    end
    count <= COUNT_W'(total_next);
  end

endmodule

>>> hw/rtl/greedy_weighted_set_cover_top.sv
// Top level of the greedy weighted set cover engine
// Subsets are loaded one member or one cost per item (add member and set cost are a
// read-modify-write of the subset's row, read in idle and written in the load state;
// clear is done in idle). A run item marks the first element_count elements uncovered and
// then makes picks until all are covered or no unchosen subset covers anything new. Each
// pick scans subsets 0 .. set_count-1 through one shared popcount tree and one shared
// multiplier: a subset already chosen is skipped, one that covers nothing new or is the
// first candidate takes a row read plus the three-stage popcount, and every other candidate
// also takes the multiply states MUL_A and MUL_B and a compare for the exact ratio test.
// A pick closes the scan and hands off its result through the emit state. The block
// accepts no item during a run; a result waits in the output register while the block
// goes on to the next pick, and the run stalls only if a second result is ready first.
`include "greedy_weighted_set_cover_top_defines.svh"

module greedy_weighted_set_cover_top import gwsc_pkg::*; #(
  parameter int MAX_SETS     = DEF_MAX_SETS,
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int COST_WIDTH   = DEF_COST_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // subset_index, element_number, cost_value
  input  logic [CMD_W-1:0]      s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // chosen_subset, left_uncovered
  output logic                  m_tuser,   // status
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SCAN_W = $clog2(MAX_SETS + 1);
  localparam int POP_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ROW_W  = COST_WIDTH + MAX_ELEMENTS;
  localparam int PROD_W = COST_WIDTH + LEFT_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_POP   = 8'b0000_1000,
    S_MUL_A = 8'b0001_0000,
    S_MUL_B = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state;

  cmd_t                  in_cmd;
  logic [SUBSET_W-1:0]   in_subset;
  logic [ELEM_NUM_W-1:0] in_elem;
  logic [COST_IN_W-1:0]  in_cost;
  logic                  subset_ok;
  logic                  elem_ok;
  logic [MAX_ELEMENTS-1:0] elem_onehot;

  logic [SET_COUNT_W-1:0]  set_count;
  logic [ELEM_COUNT_W-1:0] element_count;
  logic [SCAN_W-1:0]       ns;
  logic [LEFT_W-1:0]       ne;
  logic [MAX_ELEMENTS-1:0] unc_init;

  logic [ROW_W-1:0]   mem [MAX_SETS];
  logic [MAX_SETS-1:0] valid_row;
  logic [ROW_W-1:0]   row_q;
  logic               row_valid_q;
  logic [ROW_W-1:0]   row_eff;
  logic [MAX_ELEMENTS-1:0] row_members;
  logic [COST_WIDTH-1:0]   row_cost;
  logic               rd_en;
  logic [SET_W-1:0]   rd_addr;
  logic               wr_en;
  logic [ROW_W-1:0]   wr_row;

  logic                    ld_is_cost;
  logic [SET_W-1:0]        ld_addr;
  logic [MAX_ELEMENTS-1:0] ld_bit;
  logic [COST_WIDTH-1:0]   ld_cost;

  logic [MAX_ELEMENTS-1:0] uncovered;
  logic [MAX_SETS-1:0]     chosen;
  logic [SCAN_W-1:0]       scan_idx;
  logic [SCAN_W-1:0]       scan_end;
  logic [SET_W-1:0]        scan_sel;
  logic                    scan_done;
  logic [LEFT_W-1:0]       left;
  logic [LEFT_W-1:0]       left_after;
  logic                    found;
  logic [SET_W-1:0]        best;
  logic [LEFT_W-1:0]       best_new;
  logic [COST_WIDTH-1:0]   best_cost;
  logic [MAX_ELEMENTS-1:0] best_mem;
  logic [LEFT_W-1:0]       cand_new;
  logic [1:0]              pop_wait;
  logic [POP_W-1:0]        pop_cnt;
  logic [LEFT_W-1:0]       new_cnt;
  logic [COST_WIDTH-1:0]   mul_a;
  logic [LEFT_W-1:0]       mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic [PROD_W-1:0]       prod_a;
  logic [PROD_W-1:0]       prod_b;
  logic                    pick_now;
  logic                    out_free;

  logic [SUBSET_W-1:0] res_subset;
  logic [LEFT_W-1:0]   res_left;
  logic                res_status;
  logic                res_last;
  logic [SUBSET_W-1:0] out_subset;
  logic [LEFT_W-1:0]   out_left;
  logic                out_status;
  logic                out_last;

  assign in_cmd    = cmd_t'(s_tuser);
  assign in_subset = s_tdata[4:0];
  assign in_elem   = s_tdata[11:5];
  assign in_cost   = s_tdata[27:12];
  assign subset_ok = int'(in_subset) < MAX_SETS;
  assign elem_ok   = int'(in_elem) < MAX_ELEMENTS;
  assign elem_onehot = MAX_ELEMENTS'(1) << in_elem;

  assign ns = (int'(set_count) > MAX_SETS) ? SCAN_W'(MAX_SETS) : SCAN_W'(set_count);
  assign ne = (int'(element_count) > MAX_ELEMENTS) ? LEFT_W'(MAX_ELEMENTS) : element_count;

  always_comb begin
    for (int e = 0; e < MAX_ELEMENTS; e++) begin
      unc_init[e] = e < int'(ne);
    end
  end

  assign s_tready   = (state == S_IDLE);
  assign row_eff    = row_valid_q ? row_q : '0;
  assign row_members = row_eff[MAX_ELEMENTS-1:0];
  assign row_cost   = row_eff[ROW_W-1:MAX_ELEMENTS];
  assign scan_sel   = scan_idx[SET_W-1:0];
  assign scan_done  = (scan_idx == scan_end);
  assign left_after = left - best_new;
  assign new_cnt    = LEFT_W'(pop_cnt);
  assign pick_now   = (state == S_RD) && scan_done && found;
  assign out_free   = !m_tvalid || m_tready;

  assign mul_a = (state == S_MUL_A) ? row_cost : best_cost;
  assign mul_b = (state == S_MUL_A) ? best_new : cand_new;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_sel;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && (in_cmd == CMD_ADD || in_cmd == CMD_COST)) begin
          rd_en   = 1'b1;
          rd_addr = SET_W'(in_subset);
        end
      end
      S_RD: begin
        rd_en = !scan_done && !chosen[scan_sel];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en  = (state == S_LOAD);
  assign wr_row = ld_is_cost ? {ld_cost, row_members} : {row_cost, row_members | ld_bit};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[ld_addr] <= wr_row;
    end
  end

  gwsc_popcount #(
    .WIDTH   (MAX_ELEMENTS),
    .COUNT_W (POP_W)
  ) u_popcount (
    .clk   (clk),
    .bits  (row_members & uncovered),
    .count (pop_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      set_count     <= SET_COUNT_RESET;
      element_count <= ELEM_COUNT_RESET;
      valid_row     <= '0;
      row_valid_q   <= 1'b0;
      chosen        <= '0;
      uncovered     <= '0;
      scan_idx      <= '0;
      scan_end      <= '0;
      found         <= 1'b0;
      pop_wait      <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SET_COUNT:     set_count     <= cfg_wdata[SET_COUNT_W-1:0];
          CFG_ELEMENT_COUNT: element_count <= cfg_wdata;
          default:           set_count     <= set_count;
        endcase
      end
      if (rd_en) begin
        row_valid_q <= valid_row[rd_addr];
      end
      if (m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            unique case (in_cmd)
              CMD_CLEAR: begin
                valid_row <= '0;
                chosen    <= '0;
                uncovered <= '0;
              end
              CMD_ADD: begin
                if (subset_ok && elem_ok) begin
                  ld_is_cost <= 1'b0;
                  ld_addr    <= SET_W'(in_subset);
                  ld_bit     <= elem_onehot;
                  state      <= S_LOAD;
                end
              end
              CMD_COST: begin
                if (subset_ok) begin
                  ld_is_cost <= 1'b1;
                  ld_addr    <= SET_W'(in_subset);
                  ld_cost    <= COST_WIDTH'(in_cost);
                  state      <= S_LOAD;
                end
              end
              CMD_RUN: begin
                uncovered <= unc_init;
                chosen    <= '0;
                left      <= ne;
                scan_end  <= ns;
                scan_idx  <= '0;
                found     <= 1'b0;
                if (ne != '0) begin
                  state <= S_RD;
                end
              end
            endcase
          end
        end
        S_LOAD: begin
          valid_row[ld_addr] <= 1'b1;
          state              <= S_IDLE;
        end
        S_RD: begin
          if (scan_done) begin
            if (found) begin
              chosen[best] <= 1'b1;
              uncovered    <= uncovered & ~best_mem;
              left         <= left_after;
              res_subset   <= SUBSET_W'(best);
              res_left     <= left_after;
              res_status   <= 1'b0;
              res_last     <= (left_after == '0);
            end else begin
              res_subset <= '0;
              res_left   <= left;
              res_status <= 1'b1;
              res_last   <= 1'b1;
            end
            state <= S_EMIT;
          end else if (chosen[scan_sel]) begin
            scan_idx <= scan_idx + 1'b1;
          end else begin
            pop_wait <= '0;
            state    <= S_POP;
          end
        end
        S_POP: begin
          if (pop_wait != 2'd3) begin
            pop_wait <= pop_wait + 1'b1;
          end else if (new_cnt == '0) begin
            scan_idx <= scan_idx + 1'b1;
            state    <= S_RD;
          end else if (!found) begin
            found     <= 1'b1;
            best      <= scan_sel;
            best_new  <= new_cnt;
            best_cost <= row_cost;
            best_mem  <= row_members;
            scan_idx  <= scan_idx + 1'b1;
            state     <= S_RD;
          end else begin
            cand_new <= new_cnt;
            state    <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          prod_a <= mul_p;
          state  <= S_MUL_B;
        end
        S_MUL_B: begin
          prod_b <= mul_p;
          state  <= S_CMP;
        end
        S_CMP: begin
          if (prod_a < prod_b) begin
            best      <= scan_sel;
            best_new  <= cand_new;
            best_cost <= row_cost;
            best_mem  <= row_members;
          end
          scan_idx <= scan_idx + 1'b1;
          state    <= S_RD;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_subset <= res_subset;
            out_left   <= res_left;
            out_status <= res_status;
            out_last   <= res_last;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              scan_idx <= '0;
              found    <= 1'b0;
              state    <= S_RD;
            end
          end
        end
      endcase
    end
  end

  assign m_tdata = {3'b000, out_left, out_subset};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  `GWSC_ASSERT_NOW(a_pick_unchosen, pick_now, !chosen[best], "picked subset was already chosen")
  `GWSC_ASSERT_NOW(a_pick_gain, pick_now, (best_new != '0) && (best_new <= left), "pick gain out of range")
  `GWSC_ASSERT_NEXT(a_emit_hold, (state == S_EMIT) && !out_free, state == S_EMIT, "result dropped while output busy")
  `GWSC_ASSERT_NEXT(a_last_idle, (state == S_EMIT) && out_free && res_last, state == S_IDLE, "run did not end after final result")

endmodule
